>>> hw/rtl/srep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srep_pkg: shared types and constants
// Coordinate widths, stage payload and the divider cell payload.
// ----------------------------------------------------------------------------
package srep_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned CrossBits = ProdBits + 1;
  // quotient magnitude stays below 2^CoordBits; one extra bit for safety
  localparam int unsigned QuotBits  = CoordBits + 1;
  localparam int unsigned NumBits   = ProdBits;
  localparam int unsigned DivBits   = DiffBits;
  localparam int unsigned RemBits   = DivBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;

  // one request in flight through the divider chain
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic                horiz;
    logic                neg;
    coord_t              base;    // start coordinate the offset adds to
    coord_t              fixed;   // coordinate taken from the edge
    logic [NumBits-1:0]  num;     // numerator magnitude, shifts out MSB first
    logic [DivBits-1:0]  den;     // divisor magnitude
    logic [RemBits-1:0]  rem;
    logic [QuotBits-1:0] quo;
  } div_cell_t;

endpackage

>>> hw/rtl/srep_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srep_seg_if / srep_pt_if: request channels
// Valid/ready channels for segment queries and crossing results.
// ----------------------------------------------------------------------------
interface srep_seg_if;
  import srep_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  coord_t lower_left_x;
  coord_t lower_left_y;
  coord_t upper_right_x;
  coord_t upper_right_y;
  modport source (output valid, start_x, start_y, end_x, end_y, lower_left_x,
                  lower_left_y, upper_right_x, upper_right_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, lower_left_x,
                lower_left_y, upper_right_x, upper_right_y, output ready);
endinterface

interface srep_pt_if;
  import srep_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t point_x;
  coord_t point_y;
  modport source (output valid, hit, point_x, point_y, input ready);
  modport sink (input valid, hit, point_x, point_y, output ready);
endinterface

>>> hw/rtl/segment_rect_entry_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_rect_entry_point: segment versus rectangle edge crossing
// Pipelined edge tests followed by a chain of restoring-division cells.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  seg_i    | in  | start, end, lower-left, upper-right (signed Q16.16)
//  pt_o     | out | hit, point_x, point_y
//
// One request enters per cycle. The pipeline is 4 front stages, one division
// cell per numerator bit (NumBits), and one output register.
// The whole pipeline advances together; it holds while the output register
// is full and not taken. Reset clears all valid flags only.
// ----------------------------------------------------------------------------
module segment_rect_entry_point import srep_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  srep_seg_if.sink seg_i,
  srep_pt_if.source pt_o
);

  // advance the whole pipe when the output slot is free or being taken
  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || pt_o.ready;
  assign seg_i.ready = en;

  div_cell_t chain [NumBits+1];

  srep_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (seg_i.valid),
    .sx_i    (seg_i.start_x),
    .sy_i    (seg_i.start_y),
    .ex_i    (seg_i.end_x),
    .ey_i    (seg_i.end_y),
    .llx_i   (seg_i.lower_left_x),
    .lly_i   (seg_i.lower_left_y),
    .urx_i   (seg_i.upper_right_x),
    .ury_i   (seg_i.upper_right_y),
    .cell_o  (chain[0])
  );

  // one quotient bit per cell
  for (genvar g = 0; g < NumBits; g++) begin : g_div
    srep_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  // round half away from zero on magnitude, then apply sign and offset
  div_cell_t fin;
  logic [QuotBits-1:0] qr;
  coord_t off, coord;
  logic   hit_q;
  coord_t px_q, py_q;

  always_comb begin
    fin   = chain[NumBits];
    qr    = fin.quo + QuotBits'(fin.rem >= ({1'b0, fin.den} - fin.rem));
    off   = fin.neg ? coord_t'(-qr) : coord_t'(qr);
    coord = fin.base + off;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= fin.hit;
      if (!fin.hit) begin
        px_q <= '0;
        py_q <= '0;
      end else if (fin.horiz) begin
        px_q <= coord;
        py_q <= fin.fixed;
      end else begin
        px_q <= fin.fixed;
        py_q <= coord;
      end
    end
  end

  assign pt_o.valid   = out_valid_q;
  assign pt_o.hit     = hit_q;
  assign pt_o.point_x = px_q;
  assign pt_o.point_y = py_q;

endmodule

>>> hw/rtl/srep_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srep_div_cell: one restoring-division step
// Shift one numerator bit into the remainder, subtract when possible.
// ----------------------------------------------------------------------------
module srep_div_cell import srep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  div_cell_t cell_i,
  output div_cell_t cell_o
);

  div_cell_t          cell_d, data_q;
  logic               valid_q;
  logic [RemBits-1:0] shifted;
  logic [RemBits-1:0] diff;

  always_comb begin
    shifted = {cell_i.rem[RemBits-2:0], cell_i.num[NumBits-1]};
    diff    = shifted - {1'b0, cell_i.den};
    cell_d  = cell_i;
    cell_d.num = {cell_i.num[NumBits-2:0], 1'b0};
    if (!diff[RemBits-1]) begin
      cell_d.rem = diff;
      cell_d.quo = {cell_i.quo[QuotBits-2:0], 1'b1};
    end else begin
      cell_d.rem = shifted;
      cell_d.quo = {cell_i.quo[QuotBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= cell_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

>>> hw/rtl/srep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srep_front: edge tests
// Differences, cross products and parameter range checks for both edges,
// then selection of the hit edge (horizontal before vertical) and setup of the division.
// ----------------------------------------------------------------------------
module srep_front import srep_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  coord_t    sx_i,
  input  coord_t    sy_i,
  input  coord_t    ex_i,
  input  coord_t    ey_i,
  input  coord_t    llx_i,
  input  coord_t    lly_i,
  input  coord_t    urx_i,
  input  coord_t    ury_i,
  output div_cell_t cell_o
);

  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [CrossBits-1:0] cross_t;

  // stage 1: differences
  logic  s1_valid_q;
  diff_t dx_q, dy_q, ehx_q, evy_q, whx_q, why_q, wvx_q, wvy_q;
  coord_t s1_sx_q, s1_sy_q, s1_hy_q, s1_vx_q;
  diff_t dx_d, dy_d;
  coord_t hy_d, vx_d;

  always_comb begin
    dx_d = diff_t'(ex_i) - diff_t'(sx_i);
    dy_d = diff_t'(ey_i) - diff_t'(sy_i);
    hy_d = dy_d[DiffBits-1] ? ury_i : lly_i;
    vx_d = dx_d[DiffBits-1] ? urx_i : llx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      ehx_q   <= diff_t'(urx_i) - diff_t'(llx_i);
      evy_q   <= diff_t'(ury_i) - diff_t'(lly_i);
      whx_q   <= diff_t'(llx_i) - diff_t'(sx_i);
      why_q   <= diff_t'(hy_d) - diff_t'(sy_i);
      wvx_q   <= diff_t'(vx_d) - diff_t'(sx_i);
      wvy_q   <= diff_t'(lly_i) - diff_t'(sy_i);
      s1_sx_q <= sx_i;
      s1_sy_q <= sy_i;
      s1_hy_q <= hy_d;
      s1_vx_q <= vx_d;
    end
  end

  // stage 2: products. Horizontal edge: E=(ehx,0); vertical: E=(0,evy).
  // den_h = -dy*ehx, sn_h = dy*whx - dx*why, tn_h = -why*ehx
  // den_v = dx*evy,  sn_v = dy*wvx - dx*wvy, tn_v = wvx*evy
  logic  s2_valid_q;
  prod_t p_dyehx_q, p_dywhx_q, p_dxwhy_q, p_whyehx_q;
  prod_t p_dxevy_q, p_dywvx_q, p_dxwvy_q, p_wvxevy_q;
  prod_t p_whydx_q, p_wvxdy_q;
  diff_t s2_dx_q, s2_dy_q;
  coord_t s2_sx_q, s2_sy_q, s2_hy_q, s2_vx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_dyehx_q  <= prod_t'(dy_q) * prod_t'(ehx_q);
      p_dywhx_q  <= prod_t'(dy_q) * prod_t'(whx_q);
      p_dxwhy_q  <= prod_t'(dx_q) * prod_t'(why_q);
      p_whyehx_q <= prod_t'(why_q) * prod_t'(ehx_q);
      p_dxevy_q  <= prod_t'(dx_q) * prod_t'(evy_q);
      p_dywvx_q  <= prod_t'(dy_q) * prod_t'(wvx_q);
      p_dxwvy_q  <= prod_t'(dx_q) * prod_t'(wvy_q);
      p_wvxevy_q <= prod_t'(wvx_q) * prod_t'(evy_q);
      p_whydx_q  <= prod_t'(why_q) * prod_t'(dx_q);
      p_wvxdy_q  <= prod_t'(wvx_q) * prod_t'(dy_q);
      s2_dx_q    <= dx_q;
      s2_dy_q    <= dy_q;
      s2_sx_q    <= s1_sx_q;
      s2_sy_q    <= s1_sy_q;
      s2_hy_q    <= s1_hy_q;
      s2_vx_q    <= s1_vx_q;
    end
  end

  // stage 3: cross sums
  logic   s3_valid_q;
  cross_t den_h_q, sn_h_q, tn_h_q, den_v_q, sn_v_q, tn_v_q;
  prod_t  s3_ph_q, s3_pv_q;
  diff_t  s3_dx_q, s3_dy_q;
  coord_t s3_sx_q, s3_sy_q, s3_hy_q, s3_vx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_h_q <= -cross_t'(p_dyehx_q);
      sn_h_q  <= cross_t'(p_dywhx_q) - cross_t'(p_dxwhy_q);
      tn_h_q  <= -cross_t'(p_whyehx_q);
      den_v_q <= cross_t'(p_dxevy_q);
      sn_v_q  <= cross_t'(p_dywvx_q) - cross_t'(p_dxwvy_q);
      tn_v_q  <= cross_t'(p_wvxevy_q);
      s3_ph_q <= p_whydx_q;
      s3_pv_q <= p_wvxdy_q;
      s3_dx_q <= s2_dx_q;
      s3_dy_q <= s2_dy_q;
      s3_sx_q <= s2_sx_q;
      s3_sy_q <= s2_sy_q;
      s3_hy_q <= s2_hy_q;
      s3_vx_q <= s2_vx_q;
    end
  end

  // stage 4: range checks, edge choice, divider setup
  function automatic logic unit_ratio(cross_t n, cross_t d);
    logic r;
    if (d == '0) begin
      r = 1'b0;
    end else if (!d[CrossBits-1]) begin
      r = !n[CrossBits-1] && !(d < n);
    end else begin
      r = !(n < d) && (n[CrossBits-1] || n == '0);
    end
    return r;
  endfunction

  logic      hit_h, hit_v;
  prod_t     num_s;
  diff_t     den_s;
  div_cell_t cell_d, cell_data_q;
  logic      cell_valid_q;

  always_comb begin
    hit_h = unit_ratio(sn_h_q, den_h_q) && unit_ratio(tn_h_q, den_h_q);
    hit_v = unit_ratio(sn_v_q, den_v_q) && unit_ratio(tn_v_q, den_v_q);
    num_s = hit_h ? s3_ph_q : s3_pv_q;
    den_s = hit_h ? s3_dy_q : s3_dx_q;
    cell_d       = '0;
    cell_d.valid = s3_valid_q;
    cell_d.hit   = hit_h || hit_v;
    cell_d.horiz = hit_h;
    cell_d.neg   = num_s[ProdBits-1] ^ den_s[DiffBits-1];
    cell_d.base  = hit_h ? s3_sx_q : s3_sy_q;
    cell_d.fixed = hit_h ? s3_hy_q : s3_vx_q;
    cell_d.num   = num_s[ProdBits-1] ? NumBits'(-num_s) : NumBits'(num_s);
    cell_d.den   = den_s[DiffBits-1] ? DivBits'(-den_s) : DivBits'(den_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_valid_q <= 1'b0;
    end else if (en_i) begin
      cell_valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_data_q <= cell_d;
    end
  end

  always_comb begin
    cell_o       = cell_data_q;
    cell_o.valid = cell_valid_q;
  end

endmodule
